// ===== rtl/bsa_pkg.sv =====
// Shared constants, result codes and placement modes for the bitmap span allocator.
// Depends on nothing; used by bitmap_span_allocator_core.
package bsa_pkg;

  localparam int RAM_BYTES_DEF = 2048;
  localparam int PAGE_BYTES    = 256;
  localparam int WORD_BITS     = 64;
  localparam int SIZE_W        = 12;
  localparam int SPAN_W        = 11;
  localparam int IN_DATA_W     = 88;
  localparam int OUT_DATA_W    = 16;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_ALLOC  = 2'd1,
    ST_NOROOM = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ZP_AVOID   = 2'd0,
    ZP_ALLOWED = 2'd1,
    ZP_ONLY    = 2'd2
  } zp_mode_t;

  typedef enum logic [1:0] {
    FIT_ALIGN = 2'd0,
    FIT_ANY   = 2'd1,
    FIT_ZERO  = 2'd2,
    FIT_UPPER = 2'd3
  } fit_mode_t;

endpackage

// ===== rtl/bitmap_span_allocator_core.sv =====
// First-fit span allocator over a free-byte bitmap held in a word memory.
// Depends on bsa_pkg for constants, result codes and placement modes.
//
// The free map lives in a memory of RAM_BYTES/64 words of 64 bits and is
// scanned one bit per cycle through a 64-bit shift register, each word
// fetched (S_RD) before its bits are shifted (S_SCAN). A load request
// writes its word when accepted and goes straight to its result. An
// allocation scans the map word by word, makes at most two passes (the
// page-bounded try, then the fallback first fit), and on success clears
// the span word by word (read, shift, write back); the scan ends as soon
// as a fitting run is found. One request is in flight at a time, and a
// finished result waits in the output register while the next request is
// taken. After reset a clearing pass over all RAM_BYTES/64 words zeroes the
// map while s_axis_tready stays low; the map then reads as all bytes used.
module bitmap_span_allocator_core #(
  parameter int RAM_BYTES = bsa_pkg::RAM_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // word_index[4:0], word_value[68:5], alloc_size[80:69], zp_mode[82:81],
  // page_strict[83], zero fill above.
  input  logic [bsa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type[0].
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[1:0], span_addr[12:2], zero fill above.
  output logic [bsa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int NW  = RAM_BYTES / bsa_pkg::WORD_BITS;
  localparam int WIW = (NW > 1) ? $clog2(NW) : 1;
  localparam int AW  = WIW + 6;
  localparam int EW  = ((AW > bsa_pkg::SIZE_W) ? AW : bsa_pkg::SIZE_W) + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_RD   = 8'b00000010,
    S_SCAN = 8'b00000100,
    S_CRD  = 8'b00001000,
    S_CSH  = 8'b00010000,
    S_CWR  = 8'b00100000,
    S_DONE = 8'b01000000,
    S_INIT = 8'b10000000
  } state_t;

  state_t state;

  logic [bsa_pkg::WORD_BITS-1:0] mem [NW];
  logic [bsa_pkg::WORD_BITS-1:0] sh;

  logic [WIW-1:0]                wc;
  logic [5:0]                    bc;
  logic [bsa_pkg::SIZE_W-1:0]    sz;
  logic [1:0]                    zp;
  logic                          insist;
  bsa_pkg::fit_mode_t            mode;
  logic                          active;
  logic [bsa_pkg::SIZE_W-1:0]    cnt;
  logic [AW-1:0]                 cstart;
  logic [AW-1:0]                 start;
  logic [EW-1:0]                 end_a;
  bsa_pkg::status_t              status;
  bsa_pkg::status_t              out_status;
  logic [bsa_pkg::SPAN_W-1:0]    span_addr;

  logic [4:0]                    in_widx;
  logic [bsa_pkg::WORD_BITS-1:0] in_wval;
  logic [bsa_pkg::SIZE_W-1:0]    in_size;
  logic [1:0]                    in_zp;
  logic                          in_insist;
  logic                          accept;

  logic [AW-1:0]                 a;
  logic [7:0]                    off;
  logic                          in_p0;
  logic                          big;
  logic [8:0]                    lim;
  logic                          pos_ok;
  logic                          f;
  logic [bsa_pkg::SIZE_W-1:0]    cnt_inc;
  logic                          found;
  logic [AW-1:0]                 found_addr;
  logic                          last_word;
  bsa_pkg::fit_mode_t            fb_mode;
  logic                          do_align;
  logic                          keep;
  logic                          clr_last;
  logic                          restart;

  assign in_widx   = s_axis_tdata[4:0];
  assign in_wval   = s_axis_tdata[68:5];
  assign in_size   = s_axis_tdata[80:69];
  assign in_zp     = s_axis_tdata[82:81];
  assign in_insist = s_axis_tdata[83];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {3'b000, span_addr, out_status};

  assign a         = {wc, bc};
  assign off       = a[7:0];
  assign in_p0     = ({1'b0, a} < (AW + 1)'(bsa_pkg::PAGE_BYTES));
  assign big       = (sz > bsa_pkg::SIZE_W'(bsa_pkg::PAGE_BYTES));
  assign lim       = 9'(bsa_pkg::PAGE_BYTES) - 9'(sz);
  assign f         = sh[0];
  assign cnt_inc   = cnt + 1'b1;
  assign last_word = (wc == WIW'(NW - 1));
  assign do_align  = (sz > bsa_pkg::SIZE_W'(1)) && (insist || !big);
  assign restart   = !found && (bc == 6'd63) && last_word &&
                     (mode == bsa_pkg::FIT_ALIGN) && !insist;

  always_comb begin
    if (zp == bsa_pkg::ZP_ALLOWED && sz == bsa_pkg::SIZE_W'(1)) begin
      fb_mode = bsa_pkg::FIT_ANY;
    end else if (zp[1]) begin
      fb_mode = bsa_pkg::FIT_ZERO;
    end else begin
      fb_mode = bsa_pkg::FIT_UPPER;
    end
  end

  always_comb begin
    case (mode)
      bsa_pkg::FIT_ALIGN: pos_ok = big ? (off == 8'd0) : ({1'b0, off} <= lim);
      bsa_pkg::FIT_ANY:   pos_ok = 1'b1;
      bsa_pkg::FIT_ZERO:  pos_ok = in_p0 && !big && ({1'b0, off} <= lim);
      bsa_pkg::FIT_UPPER: pos_ok = !in_p0;
      default:            pos_ok = 1'b0;
    endcase
  end

  always_comb begin
    found      = 1'b0;
    found_addr = a;
    if (f) begin
      if (active) begin
        found      = (cnt_inc == sz);
        found_addr = cstart;
      end else if (pos_ok) begin
        found = (sz == bsa_pkg::SIZE_W'(1));
      end
    end
  end

  assign keep     = !((EW'(a) >= EW'(start)) && (EW'(a) < end_a));
  assign clr_last = last_word || ((EW'({wc, 6'd0}) + EW'(bsa_pkg::WORD_BITS)) >= end_a);

  // Free-map memory, fetch/shift register, request payload and found-span bounds.
  always_ff @(posedge clk) begin
    case (state)
      S_INIT: begin
        mem[wc] <= '0;
      end
      S_IDLE: begin
        if (accept) begin
          sz     <= in_size;
          zp     <= in_zp;
          insist <= in_insist;
          if (!s_axis_tuser && (32'(in_widx) < 32'(NW))) begin
            mem[WIW'(in_widx)] <= in_wval;
          end
        end
      end
      S_RD, S_CRD: begin
        sh <= mem[wc];
      end
      S_SCAN: begin
        sh <= {1'b0, sh[bsa_pkg::WORD_BITS-1:1]};
        if (found) begin
          start <= found_addr;
          end_a <= EW'(found_addr) + EW'(sz);
        end
        if (f && !active) begin
          cstart <= a;
        end
      end
      S_CSH: begin
        sh <= {f & keep, sh[bsa_pkg::WORD_BITS-1:1]};
      end
      S_CWR: begin
        mem[wc] <= sh;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      m_axis_tvalid <= 1'b0;
      wc            <= '0;
      bc            <= '0;
      active        <= 1'b0;
      cnt           <= '0;
      mode          <= bsa_pkg::FIT_ALIGN;
      status        <= bsa_pkg::ST_LOADED;
      out_status    <= bsa_pkg::ST_LOADED;
      span_addr     <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (last_word) begin
            state <= S_IDLE;
          end else begin
            wc <= wc + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            wc     <= '0;
            bc     <= '0;
            active <= 1'b0;
            cnt    <= '0;
            if (!s_axis_tuser) begin
              status <= bsa_pkg::ST_LOADED;
              state  <= S_DONE;
            end else if (in_size == '0) begin
              status <= bsa_pkg::ST_NOROOM;
              state  <= S_DONE;
            end else begin
              state <= S_RD;
              mode  <= bsa_pkg::FIT_ALIGN;
            end
          end
        end
        S_RD: begin
          if (wc == '0 && mode == bsa_pkg::FIT_ALIGN && !do_align) begin
            mode <= fb_mode;
          end
          bc    <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (restart) begin
            active <= 1'b0;
            cnt    <= '0;
          end else if (!f) begin
            active <= 1'b0;
          end else if (active) begin
            cnt <= cnt_inc;
          end else if (pos_ok) begin
            active <= 1'b1;
            cnt    <= bsa_pkg::SIZE_W'(1);
          end
          bc <= bc + 1'b1;
          if (found) begin
            wc    <= found_addr[AW-1:6];
            state <= S_CRD;
          end else if (bc == 6'd63) begin
            if (!last_word) begin
              wc    <= wc + 1'b1;
              state <= S_RD;
            end else if (mode == bsa_pkg::FIT_ALIGN && !insist) begin
              wc    <= '0;
              mode  <= fb_mode;
              state <= S_RD;
            end else begin
              status <= bsa_pkg::ST_NOROOM;
              state  <= S_DONE;
            end
          end
        end
        S_CRD: begin
          bc    <= '0;
          state <= S_CSH;
        end
        S_CSH: begin
          bc <= bc + 1'b1;
          if (bc == 6'd63) begin
            state <= S_CWR;
          end
        end
        S_CWR: begin
          if (clr_last) begin
            status <= bsa_pkg::ST_ALLOC;
            state  <= S_DONE;
          end else begin
            wc    <= wc + 1'b1;
            state <= S_CRD;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_status    <= status;
            span_addr     <= (status == bsa_pkg::ST_ALLOC) ?
                             bsa_pkg::SPAN_W'(start) : '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/bitmap_span_allocator_core_tb.sv =====
// Testbench for bitmap_span_allocator_core: loads free-map words and allocates spans,
// checking every status and address against a predictor that keeps its own free map.
// Depends on bsa_pkg and the RTL of bitmap_span_allocator_core only.
`timescale 1ns / 100ps

module bitmap_span_allocator_core_tb;

  localparam int  RAM_BYTES     = bsa_pkg::RAM_BYTES_DEF;
  localparam int  RANDOM_ITEMS  = 1400;
  localparam int  LONG_HOLD     = 8000;
  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_ALLOC    = 1'b1;
  localparam logic [1:0] ZP_ONLY_ALT = 2'd3;

  typedef struct {
    logic                       req;
    logic [4:0]                 word_index;
    logic [63:0]                word_value;
    logic [bsa_pkg::SIZE_W-1:0] alloc_size;
    logic [1:0]                 zp;
    logic                       insist;
  } span_request_t;

  typedef struct {
    bsa_pkg::status_t           status;
    logic [bsa_pkg::SPAN_W-1:0] span_addr;
  } span_answer_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [bsa_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [bsa_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  span_request_t request_q[$];
  span_answer_t  answer_q[$];
  span_answer_t  want;

  bit free_bytes[RAM_BYTES];
  int free_run[RAM_BYTES + 1];

  int  error_count = 0;
  int  accepted_count = 0;
  int  burst_left = 1;
  int  gap_left = 0;
  int  stall_left = 0;
  int  calm_left = 0;
  bit  took_request = 1'b0;
  bit  long_hold_done = 1'b0;

  bitmap_span_allocator_core dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int find_span(int size, logic [1:0] zp, logic insist);
    int  a;
    int  off;
    bit  pos_ok;
    if (size > 1 && (insist || size <= bsa_pkg::PAGE_BYTES)) begin
      for (a = 0; a < RAM_BYTES; a++) begin
        off = a % bsa_pkg::PAGE_BYTES;
        pos_ok = (size > bsa_pkg::PAGE_BYTES) ? (off == 0) :
                 (off <= bsa_pkg::PAGE_BYTES - size);
        if (pos_ok && free_run[a] >= size) return a;
      end
      if (insist) return -1;
    end
    if (zp == bsa_pkg::ZP_ALLOWED && size == 1) begin
      for (a = 0; a < RAM_BYTES; a++)
        if (free_bytes[a]) return a;
      return -1;
    end
    if (zp >= bsa_pkg::ZP_ONLY) begin
      for (a = 0; a < bsa_pkg::PAGE_BYTES && a < RAM_BYTES; a++)
        if (a + size <= bsa_pkg::PAGE_BYTES && free_run[a] >= size) return a;
      return -1;
    end
    for (a = bsa_pkg::PAGE_BYTES; a < RAM_BYTES; a++)
      if (free_run[a] >= size) return a;
    return -1;
  endfunction

  function automatic void serve_request(span_request_t r);
    span_answer_t ans;
    int           a;
    int           b;
    int           found;
    int           size;
    ans.status = bsa_pkg::ST_NOROOM;
    ans.span_addr = '0;
    size = r.alloc_size;
    if (r.req == REQ_LOAD) begin
      for (b = 0; b < bsa_pkg::WORD_BITS; b++) begin
        a = r.word_index * bsa_pkg::WORD_BITS + b;
        if (a < RAM_BYTES) free_bytes[a] = r.word_value[b];
      end
      ans.status = bsa_pkg::ST_LOADED;
    end else if (size != 0) begin
      free_run[RAM_BYTES] = 0;
      for (a = RAM_BYTES; a > 0; a--)
        free_run[a - 1] = free_bytes[a - 1] ? free_run[a] + 1 : 0;
      found = find_span(size, r.zp, r.insist);
      if (found >= 0) begin
        for (a = found; a < found + size && a < RAM_BYTES; a++) free_bytes[a] = 1'b0;
        ans.status = bsa_pkg::ST_ALLOC;
        ans.span_addr = found[bsa_pkg::SPAN_W-1:0];
      end
    end
    answer_q.insert(answer_q.size(), ans);
  endfunction

  function automatic logic [bsa_pkg::IN_DATA_W-1:0] pack_request(span_request_t r);
    return {4'b0, r.insist, r.zp, r.alloc_size, r.word_value, r.word_index};
  endfunction

  function automatic span_request_t random_request();
    span_request_t r;
    r.req = 1'($urandom_range(0, 1));
    r.word_index = 5'($urandom_range(0, 31));
    r.word_value = {$urandom, $urandom};
    r.alloc_size = bsa_pkg::SIZE_W'($urandom_range(0, 4095));
    r.zp = 2'($urandom_range(0, 3));
    r.insist = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic add_load(int idx, logic [63:0] value);
    span_request_t r;
    r = random_request();
    r.req = REQ_LOAD;
    r.word_index = 5'(idx);
    r.word_value = value;
    request_q.insert(request_q.size(), r);
  endtask

  task automatic add_alloc(int size, logic [1:0] zp, logic insist);
    span_request_t r;
    r = random_request();
    r.req = REQ_ALLOC;
    r.alloc_size = bsa_pkg::SIZE_W'(size);
    r.zp = zp;
    r.insist = insist;
    request_q.insert(request_q.size(), r);
  endtask

  function automatic int pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return $urandom_range(1, 8);
    if (roll < 80) return $urandom_range(9, bsa_pkg::PAGE_BYTES);
    if (roll < 95) return $urandom_range(bsa_pkg::PAGE_BYTES + 1, RAM_BYTES);
    return $urandom_range(0, 4095);
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 4))
      0: return '1;
      1: return {$urandom, $urandom};
      2: return ~64'd0 << $urandom_range(0, 63);
      3: return ~64'd0 >> $urandom_range(0, 63);
      default: return {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  task automatic build_stimulus();
    int i;
    int n;
    int made;
    add_alloc(1, bsa_pkg::ZP_ALLOWED, 1'b0);
    for (i = 0; i < 8; i++) add_load(i, '1);
    add_load(31, '1);
    add_alloc(0, bsa_pkg::ZP_AVOID, 1'b0);
    add_alloc(1, bsa_pkg::ZP_ALLOWED, 1'b0);
    add_alloc(1, bsa_pkg::ZP_AVOID, 1'b0);
    add_alloc(1, bsa_pkg::ZP_ONLY, 1'b0);
    add_alloc(1, ZP_ONLY_ALT, 1'b0);
    add_alloc(200, bsa_pkg::ZP_ONLY, 1'b0);
    add_alloc(256, bsa_pkg::ZP_AVOID, 1'b1);
    add_alloc(300, bsa_pkg::ZP_AVOID, 1'b1);
    add_alloc(300, bsa_pkg::ZP_AVOID, 1'b0);
    add_alloc(2048, bsa_pkg::ZP_AVOID, 1'b1);
    add_alloc(4095, bsa_pkg::ZP_ALLOWED, 1'b0);
    add_load(2, 64'hAAAA_AAAA_AAAA_AAAA);
    add_alloc(2, bsa_pkg::ZP_ONLY, 1'b1);
    add_load(3, 64'h0);
    add_alloc(64, bsa_pkg::ZP_ONLY, 1'b0);

    made = 0;
    while (made < RANDOM_ITEMS) begin
      n = $urandom_range(0, 99);
      if (n < 8) begin
        for (i = 0; i < RAM_BYTES / bsa_pkg::WORD_BITS; i++) add_load(i, '1);
        made += RAM_BYTES / bsa_pkg::WORD_BITS;
      end else if (n < 75) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) add_load($urandom_range(0, 31), pick_word());
        made += n;
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++)
          add_alloc(pick_size(), 2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
        made += n;
      end else begin
        request_q.insert(request_q.size(), random_request());
        made++;
      end
    end
  endtask

  always @(posedge clk) begin
    took_request = !rst && s_axis_tvalid && s_axis_tready;
    if (took_request) begin
      serve_request(request_q.pop_front());
      accepted_count++;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || took_request)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (request_q.size() > 0) begin
        s_axis_tdata <= pack_request(request_q[0]);
        s_axis_tuser <= request_q[0].req;
        s_axis_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!long_hold_done && accepted_count >= 300) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) < 15) stall_left = $urandom_range(1, 25);
        else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(200, 2000);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (answer_q.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, actual status %0d addr %0d",
                 $time, m_axis_tdata[1:0], m_axis_tdata[12:2]);
        error_count++;
      end else begin
        want = answer_q.pop_front();
        if (m_axis_tdata[1:0] !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, m_axis_tdata[1:0]);
          error_count++;
        end
        if (m_axis_tdata[12:2] !== want.span_addr) begin
          $display("%0t: span_addr mismatch, expected %0d, actual %0d",
                   $time, want.span_addr, m_axis_tdata[12:2]);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(64'd400_000_000);
    $display("bitmap_span_allocator_core test failed");
    $finish;
  end

  initial begin
    build_stimulus();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (request_q.size() != 0 || answer_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("bitmap_span_allocator_core test passed");
    end else begin
      $display("bitmap_span_allocator_core test failed");
    end
    $finish;
  end

endmodule
